// ----- hw/rtl/fpd_pkg.sv -----
`default_nettype none

package fpd_pkg;

  // Field widths
  localparam int FLOW_W = 12;
  localparam int LEN_W  = 32;
  localparam int CNT_W  = 17;
  localparam int CRC_W  = 32;
  localparam int FP_W   = 64;
  localparam int RUN_W  = 32;
  localparam int STAT_W = 64;

  // Flow table size
  localparam int FLOWS  = 4096;
  localparam int ADDR_W = $clog2(FLOWS);

  // Hash constants
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [LEN_W-1:0] LEN_MULT = 32'h9E37_79B9;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_LIMIT = 2'd1;
  localparam logic [CNT_W-1:0]     HASH_LIMIT_RST = 17'd4096;

  // Command queue between front and back
  localparam int CMDQ_PTR_W = 2;
  localparam int CMDQ_DEPTH = 1 << CMDQ_PTR_W;

  typedef struct packed {
    logic [FLOW_W-1:0] flow_index;
    logic [7:0]        data_byte;
    logic              byte_valid;
    logic              first_of_send;
    logic              last_of_send;
    logic [LEN_W-1:0]  send_length;
  } in_t;

  typedef struct packed {
    logic [FLOW_W-1:0] result_flow;
    logic              is_duplicate;
    logic [FP_W-1:0]   fingerprint;
    logic [RUN_W-1:0]  duplicate_run;
    logic [STAT_W-1:0] sends_seen;
    logic [STAT_W-1:0] redundant_count;
    logic [STAT_W-1:0] redundant_volume;
  } out_t;

  // Finished send handed from front to back
  typedef struct packed {
    logic [FLOW_W-1:0] flow;
    logic [FP_W-1:0]   fp;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // One flow table entry
  typedef struct packed {
    logic [FP_W-1:0]   prior_fp;
    logic [RUN_W-1:0]  run;
    logic [STAT_W-1:0] sends;
    logic [STAT_W-1:0] dup_sends;
    logic [STAT_W-1:0] dup_bytes;
  } rec_t;

  // Reflected CRC32C over one byte, bit at a time
  function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [7:0]       b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/flow_payload_duplicate_detector.sv -----
`default_nettype none

// Flow payload duplicate detector.
// Input channel: one payload byte per request with its flow index, send
// length and first/last marks; a request is taken when push is high and full
// is low. Bytes are taken one per cycle while full is low: the CRC32C step
// runs in the front stage in the accepting cycle.
// Result channel: one record per finished nonempty send while enabled,
// oldest first; it is shown while empty is low and taken when pop is high.
// Each finished send goes through a 4-entry command queue into the flow table
// sequencer, which takes it, reads its entry into the read data register,
// computes the update and writes it back before it takes the next send;
// sends that arrive faster queue up.
// A stalled receiver holds the result register; the sequencer then waits and
// the front keeps taking bytes until the command queue fills, then full rises.
// Reset: after rst_n is released the flow table is swept to zero, one entry a
// cycle, with full high; configuration writes are taken anytime.
// Configuration: cfg_we, cfg_index (0 enabled, 1 hash_limit), cfg_data.

module flow_payload_duplicate_detector (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire fpd_pkg::in_t                   in_data,
  output logic                                empty,
  input  wire logic                           pop,
  output fpd_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          acc;
  logic          cmd_push;
  fpd_pkg::cmd_t cmd_data;
  logic          cmd_full;
  logic          cmd_pop;
  fpd_pkg::cmd_t cmd_head;
  logic          cmd_empty;
  logic          clr_busy;
  logic          out_valid;
  logic          out_take;

  // Hold off requests while the queue is full or the table is being cleared
  assign full     = cmd_full || clr_busy;
  assign acc      = push && !full;
  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

  fpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .in_item   (in_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data)
  );

  fpd_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  fpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_take  (out_take)
  );

  // No command is ever dropped at the queue
  a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  // No result shows up while the table is still being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> empty)
    else $error("result during table clear");

  // A send that is not a duplicate restarts the run
  a_run_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.is_duplicate) |-> (out_data.duplicate_run == '0))
    else $error("run count not cleared on a fresh send");

endmodule

`default_nettype wire

// ----- hw/rtl/fpd_front.sv -----
`default_nettype none

module fpd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                         acc,
  input  wire fpd_pkg::in_t                 in_item,
  output logic                              cmd_push,
  output fpd_pkg::cmd_t                     cmd_data
);

  logic                        enabled_r;
  logic [fpd_pkg::CNT_W-1:0]   hash_limit_r;
  logic [fpd_pkg::CRC_W-1:0]   crc_r;
  logic [fpd_pkg::CNT_W-1:0]   cnt_r;

  logic                        in_range;
  logic                        live;
  logic                        do_hash;
  logic [fpd_pkg::CRC_W-1:0]   crc_base;
  logic [fpd_pkg::CNT_W-1:0]   cnt_base;
  logic [fpd_pkg::CRC_W-1:0]   crc_nxt;
  logic [fpd_pkg::CNT_W-1:0]   cnt_nxt;
  logic [fpd_pkg::LEN_W-1:0]   len_prod;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b1;
      hash_limit_r <= fpd_pkg::HASH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fpd_pkg::CFG_ENABLED:    enabled_r    <= cfg_data[0];
        fpd_pkg::CFG_HASH_LIMIT: hash_limit_r <= cfg_data[fpd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the request
  assign in_range = 32'(in_item.flow_index) < 32'(fpd_pkg::FLOWS);
  assign live     = acc && enabled_r && in_range;

  // Running CRC, restarted by the first item and cleared after the last
  always_comb begin
    crc_base = in_item.first_of_send ? '0 : crc_r;
    cnt_base = in_item.first_of_send ? '0 : cnt_r;
    do_hash  = in_item.byte_valid && (cnt_base < hash_limit_r) &&
               (32'(cnt_base) < in_item.send_length);
    crc_nxt  = do_hash ? fpd_pkg::crc32c_byte(crc_base, in_item.data_byte) : crc_base;
    cnt_nxt  = do_hash ? cnt_base + fpd_pkg::CNT_W'(1) : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      cnt_r <= '0;
    end else if (live) begin
      crc_r <= in_item.last_of_send ? '0 : crc_nxt;
      cnt_r <= in_item.last_of_send ? '0 : cnt_nxt;
    end
  end

  // Fingerprint of a finished, nonempty send (length hash keeps the low word)
  assign len_prod      = in_item.send_length * fpd_pkg::LEN_MULT;
  assign cmd_push      = live && in_item.last_of_send && (in_item.send_length != '0);
  assign cmd_data.flow = in_item.flow_index;
  assign cmd_data.fp   = {crc_nxt, len_prod};
  assign cmd_data.len  = in_item.send_length;

endmodule

`default_nettype wire

// ----- hw/rtl/fpd_cmd_q.sv -----
`default_nettype none

module fpd_cmd_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fpd_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output fpd_pkg::cmd_t      head,
  output logic               empty
);

  fpd_pkg::cmd_t                  slot_r [fpd_pkg::CMDQ_DEPTH];
  logic [fpd_pkg::CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [fpd_pkg::CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [fpd_pkg::CMDQ_PTR_W:0]   count_r;
  logic                           do_push;
  logic                           do_pop;

  assign full    = count_r == (fpd_pkg::CMDQ_PTR_W+1)'(fpd_pkg::CMDQ_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fpd_back.sv -----
`default_nettype none

module fpd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_empty,
  input  wire fpd_pkg::cmd_t cmd_head,
  output logic               cmd_pop,
  output logic               clr_busy,
  output logic               out_valid,
  output fpd_pkg::out_t      out_data,
  input  wire logic          out_take
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CALC, S_WRITE} state_t;

  state_t                     state_r;
  logic [fpd_pkg::ADDR_W-1:0] clr_addr_r;
  fpd_pkg::cmd_t              cmd_r;
  fpd_pkg::rec_t              upd_r;
  logic                       dup_r;
  logic                       out_valid_r;
  fpd_pkg::out_t              out_data_r;

  fpd_pkg::rec_t              mem [fpd_pkg::FLOWS];
  fpd_pkg::rec_t              rd_data_r;

  logic [fpd_pkg::ADDR_W-1:0] flow_addr;
  logic                       rd_en;
  logic                       wr_en;
  logic [fpd_pkg::ADDR_W-1:0] wr_addr;
  fpd_pkg::rec_t              wr_data;
  logic                       out_free;
  logic                       dup_nxt;
  fpd_pkg::rec_t              upd_nxt;

  assign flow_addr = cmd_r.flow[fpd_pkg::ADDR_W-1:0];
  assign out_free  = !out_valid_r || out_take;
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty;
  assign clr_busy  = state_r == S_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Flow table ports
  assign rd_en   = state_r == S_READ;
  assign wr_en   = (state_r == S_CLEAR) || ((state_r == S_WRITE) && out_free);
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : flow_addr;
  assign wr_data = (state_r == S_CLEAR) ? '0 : upd_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[flow_addr];
  end

  // Record update: duplicate needs a prior send and a matching fingerprint
  always_comb begin
    dup_nxt = (rd_data_r.sends != '0) && !(&rd_data_r.sends) &&
              (cmd_r.fp == rd_data_r.prior_fp);
    upd_nxt.prior_fp  = cmd_r.fp;
    upd_nxt.sends     = rd_data_r.sends + fpd_pkg::STAT_W'(1);
    upd_nxt.run       = dup_nxt ? rd_data_r.run + fpd_pkg::RUN_W'(1) : '0;
    upd_nxt.dup_sends = dup_nxt ? rd_data_r.dup_sends + fpd_pkg::STAT_W'(1)
                                : rd_data_r.dup_sends;
    upd_nxt.dup_bytes = dup_nxt ? rd_data_r.dup_bytes + fpd_pkg::STAT_W'(cmd_r.len)
                                : rd_data_r.dup_bytes;
  end

  // Sequencer: clearing sweep, then read-modify-write per finished send
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Result register: loaded by the write step, cleared when taken
      if ((state_r == S_WRITE) && out_free) out_valid_r <= 1'b1;
      else if (out_take)                    out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == fpd_pkg::ADDR_W'(fpd_pkg::FLOWS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd_r   <= cmd_head;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_CALC;
        S_CALC: begin
          upd_r   <= upd_nxt;
          dup_r   <= dup_nxt;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            out_data_r.result_flow      <= cmd_r.flow;
            out_data_r.is_duplicate     <= dup_r;
            out_data_r.fingerprint      <= upd_r.prior_fp;
            out_data_r.duplicate_run    <= upd_r.run;
            out_data_r.sends_seen       <= upd_r.sends;
            out_data_r.redundant_count  <= upd_r.dup_sends;
            out_data_r.redundant_volume <= upd_r.dup_bytes;
            state_r                     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/fpd_dedup_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and config ports of the duplicate detector,
// keeps its own copy of the per-flow table and checks every record popped.
module fpd_dedup_checker
  import fpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  in_t                   in_data,
  input  logic                  empty,
  input  logic                  pop,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  // Shadow config and hashing state
  logic             en_q;
  logic [CNT_W-1:0] limit_q;
  logic [CRC_W-1:0] crc_acc;
  logic [CNT_W-1:0] hashed;

  // Per-flow records and records still owed by the block
  rec_t flow_tbl [FLOWS];
  out_t record_q [$];

  // Reflected CRC32C, one byte, LSB first
  function automatic logic [CRC_W-1:0] crc32c_shift(input logic [CRC_W-1:0] crc,
                                                    input logic [7:0]       b);
    logic [CRC_W-1:0] acc;
    logic             lsb;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      lsb = acc[0] ^ b[k];
      acc = acc >> 1;
      if (lsb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Fold one accepted request into the hash; on a finished send, update the
  // flow record and queue the record the block should emit
  task automatic predict_send_record(input in_t req);
    logic [LEN_W-1:0] len_hash;
    logic [FP_W-1:0]  fp;
    logic             dup;
    rec_t             rec;
    out_t             rec_out;
    if (!en_q || int'(req.flow_index) >= FLOWS) return;
    if (req.first_of_send) begin
      crc_acc = '0;
      hashed  = '0;
    end
    if (req.byte_valid && hashed < limit_q && {15'd0, hashed} < req.send_length) begin
      crc_acc = crc32c_shift(crc_acc, req.data_byte);
      hashed  = hashed + 1'b1;
    end
    if (!req.last_of_send) return;
    len_hash = req.send_length * LEN_MULT;
    fp       = {crc_acc, len_hash};
    crc_acc  = '0;
    hashed   = '0;
    // zero-length send: nothing recorded
    if (req.send_length == '0) return;
    rec       = flow_tbl[req.flow_index];
    rec.sends = rec.sends + 1'b1;
    dup       = (rec.sends > 1) && (fp == rec.prior_fp);
    if (dup) begin
      rec.run       = rec.run + 1'b1;
      rec.dup_sends = rec.dup_sends + 1'b1;
      rec.dup_bytes = rec.dup_bytes + 64'(req.send_length);
    end else begin
      rec.run = '0;
    end
    rec.prior_fp             = fp;
    flow_tbl[req.flow_index] = rec;
    rec_out.result_flow      = req.flow_index;
    rec_out.is_duplicate     = dup;
    rec_out.fingerprint      = fp;
    rec_out.duplicate_run    = rec.run;
    rec_out.sends_seen       = rec.sends;
    rec_out.redundant_count  = rec.dup_sends;
    rec_out.redundant_volume = rec.dup_bytes;
    record_q.push_back(rec_out);
  endtask

  task automatic show_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) $display("  %s: expected %h, got %h", name, want, got);
  endtask

  task automatic check_record(input out_t got);
    out_t want;
    if (record_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected record: flow %0d fingerprint %h", got.result_flow,
                 got.fingerprint);
      return;
    end
    want = record_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("record mismatch at %0t, flow %0d:", $realtime, want.result_flow);
        show_field("result_flow", 64'(want.result_flow), 64'(got.result_flow));
        show_field("is_duplicate", 64'(want.is_duplicate), 64'(got.is_duplicate));
        show_field("fingerprint", want.fingerprint, got.fingerprint);
        show_field("duplicate_run", 64'(want.duplicate_run), 64'(got.duplicate_run));
        show_field("sends_seen", want.sends_seen, got.sends_seen);
        show_field("redundant_count", want.redundant_count, got.redundant_count);
        show_field("redundant_volume", want.redundant_volume, got.redundant_volume);
      end
    end
  endtask

  // Results are checked before the request of the same edge is folded in;
  // config lands after both since it only affects later requests
  always @(posedge clk) begin
    if (!rst_n) begin
      en_q       = 1'b1;
      limit_q    = HASH_LIMIT_RST;
      crc_acc    = '0;
      hashed     = '0;
      mismatches = 0;
      record_q.delete();
      for (int i = 0; i < FLOWS; i++) flow_tbl[i] = '0;
    end else begin
      if (pop && !empty) check_record(out_data);
      if (push && !full) predict_send_record(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLED:    en_q    = cfg_data[0];
          CFG_HASH_LIMIT: limit_q = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= record_q.size();
  end

endmodule

// ----- tb/sv/tb_flow_payload_duplicate_detector.sv -----
`timescale 1ns / 1ps

module tb_flow_payload_duplicate_detector;
  import fpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it
  localparam int IDLE_LIMIT    = 20000;
  localparam int STALL_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_t                   in_data   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending_records;
  int idle_cycles    = 0;
  int accepted_reqs  = 0;
  int tx_burst       = 0;
  int rx_burst       = 0;
  bit long_stall_req = 1'b0;

  // A few busy flows and recurring payloads so that duplicates are common
  logic [FLOW_W-1:0] flow_pool [6];
  logic [7:0]        pat_byte  [3][8];
  logic              pat_vld   [3][8];
  int                pat_len   [3];
  in_t               prev_send [$];

  flow_payload_duplicate_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fpd_dedup_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending_records)
  );

  always #1 clk = ~clk;

  function automatic in_t make_req(input logic [FLOW_W-1:0] flow, input logic [7:0] b,
                                   input logic vld, input logic first,
                                   input logic last, input logic [LEN_W-1:0] len);
    in_t r;
    r.flow_index    = flow;
    r.data_byte     = b;
    r.byte_valid    = vld;
    r.first_of_send = first;
    r.last_of_send  = last;
    r.send_length   = len;
    return r;
  endfunction

  // Fully random request, flags included
  function automatic in_t noise_req();
    return make_req(FLOW_W'($urandom_range(0, FLOWS - 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom);
  endfunction

  // Offer one request after a random gap; returns at the accepting edge
  task automatic offer(input in_t req);
    int gap;
    if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) tx_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    accepted_reqs++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Wait for every owed record, then let trailing no-result work finish
  task automatic drain_and_settle();
    @(posedge clk);
    while (pending_records != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One send: mostly well formed with recurring or random payload,
  // sometimes a repeat of the previous send, sometimes noise
  task automatic random_send();
    in_t               items [$];
    int                sel;
    int                pick;
    int                n;
    logic [FLOW_W-1:0] flow;
    logic [LEN_W-1:0]  len;
    sel = $urandom_range(0, 99);
    if (sel < 25 && prev_send.size() > 0) begin
      items = prev_send;
    end else if (sel < 35) begin
      n = $urandom_range(1, 3);
      repeat (n) items.push_back(noise_req());
    end else begin
      if ($urandom_range(0, 9) < 7) flow = flow_pool[$urandom_range(0, 5)];
      else                          flow = FLOW_W'($urandom_range(0, FLOWS - 1));
      if ($urandom_range(0, 9) < 6) begin
        pick = $urandom_range(0, 2);
        n    = pat_len[pick];
        for (int k = 0; k < n; k++)
          items.push_back(make_req(flow, pat_byte[pick][k], pat_vld[pick][k],
                                   k == 0, k == n - 1, LEN_W'(n)));
      end else begin
        n   = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        len = LEN_W'(n);
        case ($urandom_range(0, 9))
          0: len = '0;
          1: len = $urandom;
          2: len = $urandom_range(0, n);
          default: ;
        endcase
        for (int k = 0; k < n; k++)
          items.push_back(make_req(flow, 8'($urandom_range(0, 255)),
                                   $urandom_range(0, 9) != 0,
                                   k == 0 && $urandom_range(0, 19) != 0, k == n - 1, len));
      end
      // occasionally leave the send unfinished
      if ($urandom_range(0, 19) == 0) items[items.size() - 1].last_of_send = 1'b0;
      prev_send = items;
    end
    foreach (items[k]) offer(items[k]);
  endtask

  task automatic random_phase(input int target);
    int start_cnt;
    start_cnt = accepted_reqs;
    while (accepted_reqs - start_cnt < target) random_send();
    push <= 1'b0;
  endtask

  // Directed sends: field extremes, duplicate runs and the corner rules
  task automatic run_directed();
    // single zero byte, repeated: duplicate run grows
    repeat (3) offer(make_req(12'd0, 8'h00, 1'b1, 1'b1, 1'b1, 32'd1));
    // top flow, all-ones byte and length, twice
    repeat (2) offer(make_req(FLOW_W'(FLOWS - 1), 8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    // zero-length send gives nothing
    offer(make_req(12'd5, 8'hA5, 1'b1, 1'b1, 1'b1, 32'd0));
    // length-only request
    offer(make_req(12'd7, 8'h3C, 1'b0, 1'b1, 1'b1, 32'd10));
    // three-request send with a skipped byte, then the same send again
    repeat (2) begin
      offer(make_req(12'd1, 8'h11, 1'b1, 1'b1, 1'b0, 32'd3));
      offer(make_req(12'd1, 8'h22, 1'b0, 1'b0, 1'b0, 32'd3));
      offer(make_req(12'd1, 8'h33, 1'b1, 1'b0, 1'b1, 32'd3));
    end
    // send without a first mark still starts clean
    offer(make_req(12'd2, 8'h5A, 1'b1, 1'b0, 1'b0, 32'd2));
    offer(make_req(12'd2, 8'h96, 1'b1, 1'b0, 1'b1, 32'd2));
    // more bytes than the stated length
    offer(make_req(12'd3, 8'h01, 1'b1, 1'b1, 1'b0, 32'd2));
    offer(make_req(12'd3, 8'h80, 1'b1, 1'b0, 1'b0, 32'd2));
    offer(make_req(12'd3, 8'h7F, 1'b1, 1'b0, 1'b0, 32'd2));
    offer(make_req(12'd3, 8'hFE, 1'b1, 1'b0, 1'b1, 32'd2));
    // different send on flow 1 breaks its run
    offer(make_req(12'd1, 8'h77, 1'b1, 1'b1, 1'b1, 32'd3));
    // last with nothing hashed
    offer(make_req(12'd9, 8'hC3, 1'b0, 1'b0, 1'b1, 32'd1));
    push <= 1'b0;
  endtask

  // Result side: random pops, bursts, and one long hold-off on request
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        gap = STALL_CYCLES;
      end else if (rx_burst > 0) begin
        gap = 0;
        rx_burst--;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 19) == 0) rx_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Watchdog: no request or result moving for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else                                    idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_flow_payload_duplicate_detector: errors");
      $finish;
    end
  end

  initial begin : stimulus
    flow_pool[0] = '0;
    flow_pool[1] = FLOW_W'(FLOWS - 1);
    for (int i = 2; i < 6; i++) flow_pool[i] = FLOW_W'($urandom_range(0, FLOWS - 1));
    for (int p = 0; p < 3; p++) begin
      pat_len[p] = $urandom_range(1, 6);
      for (int k = 0; k < 8; k++) begin
        pat_byte[p][k] = 8'($urandom_range(0, 255));
        pat_vld[p][k]  = $urandom_range(0, 7) != 0;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: enabled, 4096-byte window
    run_directed();
    drain_and_settle();

    // 65536-byte window, spare index poked, long receiver hold-off
    cfg_write(CFG_HASH_LIMIT, 17'h10000);
    cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    long_stall_req = 1'b1;
    tx_burst       = 40;
    random_phase(250);
    drain_and_settle();

    // one hashed byte per send
    cfg_write(CFG_HASH_LIMIT, 17'd1);
    cfg_we <= 1'b0;
    random_phase(180);
    drain_and_settle();

    // nothing hashed, enable rewritten with junk upper bits
    cfg_write(CFG_HASH_LIMIT, 17'd0);
    cfg_write(CFG_ENABLED, {16'($urandom), 1'b1});
    cfg_we <= 1'b0;
    random_phase(80);
    drain_and_settle();

    // disabled: everything ignored
    cfg_write(CFG_ENABLED, {16'($urandom), 1'b0});
    cfg_write(CFG_HASH_LIMIT, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    random_phase(60);
    drain_and_settle();

    // short window
    cfg_write(CFG_ENABLED, 17'd1);
    cfg_write(CFG_HASH_LIMIT, CFG_DATA_W'($urandom_range(2, 6)));
    cfg_we <= 1'b0;
    random_phase(250);
    drain_and_settle();

    // all-ones window value
    cfg_write(CFG_HASH_LIMIT, 17'h1FFFF);
    cfg_we <= 1'b0;
    random_phase(370);
    drain_and_settle();

    if (mismatches == 0 && pending_records == 0) begin
      $display("tb_flow_payload_duplicate_detector: clean");
    end else begin
      $display("tb_flow_payload_duplicate_detector: errors");
    end
    $finish;
  end

endmodule

// ----- flow_payload_duplicate_detector.f -----
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_front.sv
hw/rtl/fpd_cmd_q.sv
hw/rtl/fpd_back.sv
hw/rtl/flow_payload_duplicate_detector.sv
tb/sv/fpd_dedup_checker.sv
tb/sv/tb_flow_payload_duplicate_detector.sv
